// ===== rtl/core/bwfa_pkg.sv =====
// ----------------------------------------------------------------------------
// bwfa_pkg
// Shared types and codes of the best/worst-fit block allocator.
// ----------------------------------------------------------------------------
package bwfa_pkg;

	localparam logic [1:0] KIND_ALLOC   = 2'd0;
	localparam logic [1:0] KIND_RELEASE = 2'd1;
	localparam logic [1:0] KIND_COUNT   = 2'd2;

	localparam logic [1:0] STATUS_OK      = 2'd0;
	localparam logic [1:0] STATUS_NO_FIT  = 2'd1;
	localparam logic [1:0] STATUS_BAD_REL = 2'd2;

	localparam logic CFG_FIT_MODE   = 1'b0;
	localparam logic CFG_POOL_BYTES = 1'b1;

	localparam int unsigned GRAIN = 4;
	localparam logic [15:0] POOL_RESET = 16'd65532;

	typedef struct packed {
		logic [1:0]  kind;
		logic [15:0] amount;
		logic [15:0] release_address;
	} req_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [15:0] payload_address;
		logic [6:0]  small_free_count;
	} rsp_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DECIDE,
		ST_SHIFT,
		ST_WRITE_A,
		ST_WRITE_B,
		ST_FIN
	} state_t;

endpackage

// ===== rtl/core/best_worst_fit_block_allocator.sv =====
// ----------------------------------------------------------------------------
// best_worst_fit_block_allocator
// Pool allocator over an address-ordered block table held in one memory.
//
// Requests enter on in_valid/in_stall as a req_t (allocate, release, count)
// and every request gives exactly one rsp_t on out_valid/out_stall.
// Configuration: cfg_we with cfg_index 0 sets fit mode (0 best, 1 worst),
// index 1 sets the pool size and re-forms the table as one free block.
// One request is worked at a time. The table is scanned one entry per
// cycle through the memory read port; an allocate that splits or a
// release that merges then moves the later entries one per cycle and
// writes one or two entries back. A zero allocate or an unknown kind
// skips the scan and goes straight to the finish state.
// Reset leaves one free block covering the whole pool, best fit, and needs
// no clearing pass: entry 0 is supplied from registers until first written.
// A finished result waits in the output register while out_stall is high;
// a new request is still accepted then, and its own result waits until the
// register frees.
// ----------------------------------------------------------------------------
module best_worst_fit_block_allocator #(
	parameter int unsigned MAX_BLOCKS   = 64,
	parameter int unsigned HEADER_BYTES = 16,
	parameter int unsigned ADDR_BITS    = 16
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_stall,
	input  bwfa_pkg::req_t in_data,
	output logic           out_valid,
	input  logic           out_stall,
	output bwfa_pkg::rsp_t out_data,
	input  logic           cfg_we,
	input  logic           cfg_index,
	input  logic [15:0]    cfg_data
);

	localparam int unsigned IW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
	localparam int unsigned CW = $clog2(MAX_BLOCKS + 1);
	localparam int unsigned W  = ((ADDR_BITS > 16) ? ADDR_BITS : 16) + 2;
	localparam logic [W-1:0] HDR   = W'(HEADER_BYTES);
	localparam logic [W-1:0] MINP  = W'(HEADER_BYTES + bwfa_pkg::GRAIN);
	localparam logic [W-1:0] AMASK = (W'(1) << ADDR_BITS) - W'(1);

	typedef struct packed {
		logic                 used;
		logic [ADDR_BITS-1:0] offset;
		logic [ADDR_BITS-1:0] space;
	} entry_t;

	entry_t mem [MAX_BLOCKS];

	bwfa_pkg::state_t state_q, state_nx;

	logic [1:0]    kind_q;
	logic [W-1:0]  need_q;
	logic [15:0]   thr_q;
	logic [ADDR_BITS-1:0] raddr_q;
	logic [CW-1:0] total_q;
	logic          fresh_q;
	logic          fit_q;
	logic [15:0]   pool_q;

	logic [CW-1:0] iss_q;
	logic          rv_s1;
	logic [IW-1:0] idx_s1;
	logic          zero_s1;
	entry_t        rd_s1;
	entry_t        ent_s1;

	logic          found_q;
	logic [IW-1:0] pick_q;
	entry_t        pick_e_q, prev_e_q, next_e_q;
	logic [CW-1:0] cnt_q;

	logic          up_q, split_q;
	logic [1:0]    d_q;
	logic [IW-1:0] sh_ptr_q;
	logic [CW-1:0] sh_left_q;
	logic [IW-1:0] a_addr_q;
	entry_t        a_data_q, b_data_q;
	bwfa_pkg::rsp_t res_q, out_q;
	logic          out_v_q;

	logic          mem_re, mem_we;
	logic [IW-1:0] mem_raddr, mem_waddr;
	entry_t        mem_wdata;

	logic in_xfer, out_xfer, fin_load;

	// fresh entry 0 from the pool register
	logic [W-1:0] pool_c;
	entry_t       fresh_e;
	always_comb begin
		pool_c = W'(pool_q);
		if (pool_c < MINP) pool_c = MINP;
		if (pool_c > AMASK) pool_c = AMASK;
		fresh_e.used   = 1'b0;
		fresh_e.offset = '0;
		fresh_e.space  = ADDR_BITS'(pool_c - HDR);
	end

	assign ent_s1 = zero_s1 ? fresh_e : rd_s1;

	// scan evaluation
	logic [ADDR_BITS-1:0] pay_s1;
	logic elig, better, rel_hit, small_hit;
	always_comb begin
		pay_s1    = ADDR_BITS'(W'(ent_s1.offset) + HDR);
		elig      = !ent_s1.used && (W'(ent_s1.space) >= need_q);
		better    = !found_q ||
			(!fit_q && (ent_s1.space < pick_e_q.space)) ||
			(fit_q && (ent_s1.space > pick_e_q.space));
		rel_hit   = !found_q && ent_s1.used && (pay_s1 == raddr_q);
		small_hit = !ent_s1.used && (W'(ent_s1.space) < W'(thr_q));
	end

	// decision values
	logic [W-1:0]  rest;
	logic          split;
	logic          prv, nxt;
	logic [W-1:0]  mg_sp;
	logic [IW-1:0] m_idx;
	logic [1:0]    d_c;
	logic [CW-1:0] src_c;
	always_comb begin
		rest  = W'(pick_e_q.space) - need_q;
		split = (rest >= MINP) && (total_q < CW'(MAX_BLOCKS));
		prv   = (pick_q != '0) && !prev_e_q.used;
		nxt   = ((CW'(pick_q) + CW'(1)) < total_q) && !next_e_q.used;
		mg_sp = W'(pick_e_q.space)
			+ (nxt ? HDR + W'(next_e_q.space) : '0)
			+ (prv ? HDR + W'(prev_e_q.space) : '0);
		m_idx = prv ? pick_q - IW'(1) : pick_q;
		d_c   = {1'b0, prv} + {1'b0, nxt};
		src_c = CW'(m_idx) + CW'(1) + CW'(d_c);
	end

	assign in_xfer  = in_valid && !in_stall;
	assign out_xfer = out_v_q && !out_stall;
	assign fin_load = (state_q == bwfa_pkg::ST_FIN) && (!out_v_q || !out_stall);

	// next state
	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			bwfa_pkg::ST_IDLE: begin
				if (in_valid) begin
					if (in_data.kind == bwfa_pkg::KIND_ALLOC && in_data.amount == '0)
						state_nx = bwfa_pkg::ST_FIN;
					else if (in_data.kind == bwfa_pkg::KIND_ALLOC ||
						in_data.kind == bwfa_pkg::KIND_RELEASE ||
						in_data.kind == bwfa_pkg::KIND_COUNT)
						state_nx = bwfa_pkg::ST_SCAN;
					else
						state_nx = bwfa_pkg::ST_FIN;
				end
			end
			bwfa_pkg::ST_SCAN: begin
				if (iss_q == total_q && !rv_s1) state_nx = bwfa_pkg::ST_DECIDE;
			end
			bwfa_pkg::ST_DECIDE: begin
				if (!found_q || kind_q == bwfa_pkg::KIND_COUNT)
					state_nx = bwfa_pkg::ST_FIN;
				else if (kind_q == bwfa_pkg::KIND_ALLOC && split)
					state_nx = bwfa_pkg::ST_SHIFT;
				else
					state_nx = bwfa_pkg::ST_WRITE_A;
			end
			bwfa_pkg::ST_SHIFT: begin
				if (sh_left_q == '0 && !rv_s1)
					state_nx = up_q ? bwfa_pkg::ST_WRITE_A : bwfa_pkg::ST_FIN;
			end
			bwfa_pkg::ST_WRITE_A: begin
				if (kind_q == bwfa_pkg::KIND_ALLOC)
					state_nx = split_q ? bwfa_pkg::ST_WRITE_B : bwfa_pkg::ST_FIN;
				else
					state_nx = (d_q != '0) ? bwfa_pkg::ST_SHIFT : bwfa_pkg::ST_FIN;
			end
			bwfa_pkg::ST_WRITE_B: state_nx = bwfa_pkg::ST_FIN;
			bwfa_pkg::ST_FIN: begin
				if (!out_v_q || !out_stall) state_nx = bwfa_pkg::ST_IDLE;
			end
			default: state_nx = bwfa_pkg::ST_IDLE;
		endcase
	end

	// outputs of the sequencer: handshake and memory ports
	always_comb begin
		in_stall  = (state_q != bwfa_pkg::ST_IDLE);
		mem_re    = 1'b0;
		mem_raddr = '0;
		mem_we    = 1'b0;
		mem_waddr = '0;
		mem_wdata = a_data_q;
		unique case (state_q)
			bwfa_pkg::ST_SCAN: begin
				mem_re    = (iss_q != total_q);
				mem_raddr = IW'(iss_q);
			end
			bwfa_pkg::ST_SHIFT: begin
				mem_re    = (sh_left_q != '0);
				mem_raddr = sh_ptr_q;
				mem_we    = rv_s1;
				mem_waddr = up_q ? idx_s1 + IW'(1) : idx_s1 - IW'(d_q);
				mem_wdata = ent_s1;
			end
			bwfa_pkg::ST_WRITE_A: begin
				mem_we    = 1'b1;
				mem_waddr = a_addr_q;
				mem_wdata = a_data_q;
			end
			bwfa_pkg::ST_WRITE_B: begin
				mem_we    = 1'b1;
				mem_waddr = pick_q;
				mem_wdata = b_data_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) mem[mem_waddr] <= mem_wdata;
		if (mem_re) rd_s1 <= mem[mem_raddr];
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bwfa_pkg::ST_IDLE;
			total_q <= CW'(1);
			fresh_q <= 1'b1;
			fit_q   <= 1'b0;
			pool_q  <= bwfa_pkg::POOL_RESET;
			out_v_q <= 1'b0;
			rv_s1   <= 1'b0;
			iss_q   <= '0;
		end else begin
			state_q <= state_nx;
			if (cfg_we) begin
				if (cfg_index == bwfa_pkg::CFG_FIT_MODE) begin
					fit_q <= cfg_data[0];
				end else begin
					pool_q  <= cfg_data;
					total_q <= CW'(1);
					fresh_q <= 1'b1;
				end
			end
			if (mem_we && mem_waddr == '0) fresh_q <= 1'b0;
			if (state_q == bwfa_pkg::ST_DECIDE && found_q) begin
				if (kind_q == bwfa_pkg::KIND_ALLOC && split)
					total_q <= total_q + CW'(1);
				else if (kind_q == bwfa_pkg::KIND_RELEASE)
					total_q <= total_q - CW'(d_c);
			end
			if (in_xfer) iss_q <= '0;
			else if (mem_re && state_q == bwfa_pkg::ST_SCAN) iss_q <= iss_q + CW'(1);
			rv_s1 <= mem_re;
			if (fin_load) out_v_q <= 1'b1;
			else if (out_xfer) out_v_q <= 1'b0;
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		idx_s1  <= mem_raddr;
		zero_s1 <= (mem_raddr == '0) && fresh_q;
		if (in_xfer) begin
			kind_q  <= in_data.kind;
			need_q  <= ((W'(in_data.amount) + W'(3)) >> 2) << 2;
			thr_q   <= in_data.amount;
			raddr_q <= ADDR_BITS'(in_data.release_address);
			found_q <= 1'b0;
			cnt_q   <= '0;
			res_q   <= '0;
			if (in_data.kind == bwfa_pkg::KIND_ALLOC && in_data.amount == '0)
				res_q.status <= bwfa_pkg::STATUS_NO_FIT;
		end
		if (state_q == bwfa_pkg::ST_SCAN && rv_s1) begin
			unique case (kind_q)
				bwfa_pkg::KIND_ALLOC: begin
					if (elig && better) begin
						found_q  <= 1'b1;
						pick_q   <= idx_s1;
						pick_e_q <= ent_s1;
					end
				end
				bwfa_pkg::KIND_RELEASE: begin
					if (rel_hit) begin
						found_q  <= 1'b1;
						pick_q   <= idx_s1;
						pick_e_q <= ent_s1;
					end else if (!found_q) begin
						prev_e_q <= ent_s1;
					end
					if (found_q && idx_s1 == pick_q + IW'(1)) next_e_q <= ent_s1;
				end
				default: begin
					if (small_hit) cnt_q <= cnt_q + CW'(1);
				end
			endcase
		end
		if (state_q == bwfa_pkg::ST_DECIDE) begin
			split_q <= split;
			unique case (kind_q)
				bwfa_pkg::KIND_ALLOC: begin
					if (!found_q) begin
						res_q.status <= bwfa_pkg::STATUS_NO_FIT;
					end else begin
						res_q.status          <= bwfa_pkg::STATUS_OK;
						res_q.payload_address <=
							16'(ADDR_BITS'(W'(pick_e_q.offset) + HDR));
					end
					up_q      <= 1'b1;
					sh_ptr_q  <= IW'(total_q - CW'(1));
					sh_left_q <= total_q - CW'(pick_q) - CW'(1);
					if (split) begin
						a_addr_q        <= pick_q + IW'(1);
						a_data_q.used   <= 1'b0;
						a_data_q.offset <= ADDR_BITS'(W'(pick_e_q.offset) + HDR + need_q);
						a_data_q.space  <= ADDR_BITS'(rest - HDR);
					end else begin
						a_addr_q      <= pick_q;
						a_data_q      <= pick_e_q;
						a_data_q.used <= 1'b1;
					end
					b_data_q.used   <= 1'b1;
					b_data_q.offset <= pick_e_q.offset;
					b_data_q.space  <= ADDR_BITS'(need_q);
				end
				bwfa_pkg::KIND_RELEASE: begin
					res_q.status    <= found_q ? bwfa_pkg::STATUS_OK
						: bwfa_pkg::STATUS_BAD_REL;
					up_q            <= 1'b0;
					d_q             <= d_c;
					a_addr_q        <= m_idx;
					a_data_q.used   <= 1'b0;
					a_data_q.offset <= prv ? prev_e_q.offset : pick_e_q.offset;
					a_data_q.space  <= ADDR_BITS'(mg_sp);
					sh_ptr_q        <= IW'(src_c);
					sh_left_q       <= total_q - src_c;
				end
				default: begin
					res_q.small_free_count <= 7'(cnt_q);
				end
			endcase
		end
		if (state_q == bwfa_pkg::ST_SHIFT && sh_left_q != '0) begin
			sh_left_q <= sh_left_q - CW'(1);
			sh_ptr_q  <= up_q ? sh_ptr_q - IW'(1) : sh_ptr_q + IW'(1);
		end
		if (fin_load) out_q <= res_q;
	end

	assign out_valid = out_v_q;
	assign out_data  = out_q;

endmodule
